@@ rtl/kvi_pkg.sv @@
// Shared types and constants of the keyframe vertex interpolator.
package kvi_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int AXIS_W  = 16;
  localparam int CFG_W   = 48;
  localparam int BLEND_W = 8;
  localparam int SIZE_W  = 13;
  localparam int TEX_W   = 16;
  localparam int POS_W   = 24;
  localparam int UV_W    = 18;
  localparam int IDX_W   = 3;

  // Position datapath widths
  localparam int DEC_W  = 26;  // decompressed axis, signed Q.12
  localparam int DIFF_W = 27;  // next minus current
  localparam int ACC_W  = 36;  // blend accumulator, signed Q.20
  localparam int POS_LSB = 10; // Q.20 to Q.10

  // Texture divider organization
  localparam int DIV_STAGES      = 3;
  localparam int STEPS_PER_STAGE = UV_W / DIV_STAGES;
  localparam int REM_W           = SIZE_W + 1;

  // Register stages from input word to result strobe
  localparam int PIPE_DEPTH = 5;

  // Saturation limits of the normalized texture coordinate
  localparam logic signed [UV_W-1:0] UV_MAX     = 18'sh1FFFF;
  localparam logic signed [UV_W-1:0] UV_MIN     = 18'sh20000;
  localparam logic        [UV_W:0]   UV_NEG_MAG = 19'h20000;

  // Register reset values
  localparam logic [CFG_W-1:0]  SCALE_RST = 48'h1000_1000_1000;
  localparam logic [CFG_W-1:0]  TRANS_RST = 48'h0;
  localparam logic [SIZE_W-1:0] SKIN_RST  = 13'd256;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_CUR_SCALE  = 3'd0,
    CFG_CUR_TRANS  = 3'd1,
    CFG_NEXT_SCALE = 3'd2,
    CFG_NEXT_TRANS = 3'd3,
    CFG_BLEND      = 3'd4,
    CFG_SKIN_W     = 3'd5,
    CFG_SKIN_H     = 3'd6
  } cfg_idx_t;

  // Configuration bundle from the register file to the datapath
  typedef struct packed {
    logic [CFG_W-1:0]   cur_scale;
    logic [CFG_W-1:0]   cur_trans;
    logic [CFG_W-1:0]   next_scale;
    logic [CFG_W-1:0]   next_trans;
    logic [BLEND_W-1:0] blend;
    logic [SIZE_W-1:0]  skin_w;
    logic [SIZE_W-1:0]  skin_h;
  } cfg_t;

endpackage

@@ rtl/kvi_cfg_regs.sv @@
// Configuration register file of the keyframe vertex interpolator.
module kvi_cfg_regs import kvi_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; unknown indexes drop the word
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CUR_SCALE:  cfg_nxt.cur_scale  = cfg_wdata;
        CFG_CUR_TRANS:  cfg_nxt.cur_trans  = cfg_wdata;
        CFG_NEXT_SCALE: cfg_nxt.next_scale = cfg_wdata;
        CFG_NEXT_TRANS: cfg_nxt.next_trans = cfg_wdata;
        CFG_BLEND:      cfg_nxt.blend      = cfg_wdata[BLEND_W-1:0];
        CFG_SKIN_W:     cfg_nxt.skin_w     = cfg_wdata[SIZE_W-1:0];
        CFG_SKIN_H:     cfg_nxt.skin_h     = cfg_wdata[SIZE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cur_scale  <= SCALE_RST;
      cfg_r.cur_trans  <= TRANS_RST;
      cfg_r.next_scale <= SCALE_RST;
      cfg_r.next_trans <= TRANS_RST;
      cfg_r.blend      <= '0;
      cfg_r.skin_w     <= SKIN_RST;
      cfg_r.skin_h     <= SKIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/kvi_pos_lane.sv @@
// One axis of the position path: decompress both frames, blend, scale to Q14.10.
module kvi_pos_lane import kvi_pkg::*; (
  input  logic                    clk,
  input  logic [BYTE_W-1:0]       cur_b,
  input  logic [BYTE_W-1:0]       nxt_b,
  input  logic [AXIS_W-1:0]       cur_scale,
  input  logic [AXIS_W-1:0]       cur_trans,
  input  logic [AXIS_W-1:0]       next_scale,
  input  logic [AXIS_W-1:0]       next_trans,
  input  logic [BLEND_W-1:0]      blend,
  output logic signed [POS_W-1:0] pos
);

  localparam int MUL_W = AXIS_W + BYTE_W;

  logic [MUL_W-1:0]         cur_mul;
  logic [MUL_W-1:0]         nxt_mul;
  logic signed [DEC_W-1:0]  c_nxt;
  logic signed [DEC_W-1:0]  n_nxt;
  logic signed [DEC_W-1:0]  c1_r;
  logic signed [DEC_W-1:0]  n1_r;
  logic signed [DEC_W-1:0]  c2_r;
  logic signed [DIFF_W-1:0] d2_r;
  logic signed [ACC_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]  prod3_r;
  logic signed [ACC_W-1:0]  cs3_r;
  logic signed [ACC_W-1:0]  acc4_r;
  logic signed [POS_W-1:0]  pos_r;

  // Stage 1: scale * byte + translate, in Q.12
  assign cur_mul = MUL_W'(cur_scale) * MUL_W'(cur_b);
  assign nxt_mul = MUL_W'(next_scale) * MUL_W'(nxt_b);
  assign c_nxt = $signed({2'b00, cur_mul}) +
                 $signed({{4{cur_trans[AXIS_W-1]}}, cur_trans, 6'b000000});
  assign n_nxt = $signed({2'b00, nxt_mul}) +
                 $signed({{4{next_trans[AXIS_W-1]}}, next_trans, 6'b000000});

  // Stage 3: blend fraction times the frame difference
  assign prod_nxt = ACC_W'($signed({1'b0, blend})) * ACC_W'(d2_r);

  // Advance the stages
  always_ff @(posedge clk) begin
    c1_r    <= c_nxt;
    n1_r    <= n_nxt;
    c2_r    <= c1_r;
    d2_r    <= DIFF_W'(n1_r) - DIFF_W'(c1_r);
    prod3_r <= prod_nxt;
    cs3_r   <= $signed({{(ACC_W-DEC_W-8){c2_r[DEC_W-1]}}, c2_r, 8'h00});
    acc4_r  <= prod3_r + cs3_r;
    pos_r   <= acc4_r[POS_LSB+POS_W-1:POS_LSB];
  end

  assign pos = pos_r;

endmodule

@@ rtl/kvi_tex_div.sv @@
// One texture coordinate: pipelined floor division by the skin size, saturated to Q3.14.
module kvi_tex_div import kvi_pkg::*; (
  input  logic                    clk,
  input  logic signed [TEX_W-1:0] coord,
  input  logic [SIZE_W-1:0]       size,
  output logic signed [UV_W-1:0]  uv
);

  typedef struct packed {
    logic              neg;
    logic              zdiv;
    logic              ovf;
    logic              nz;
    logic [REM_W-1:0]  rem;
    logic [UV_W-1:0]   tail;
    logic [UV_W-1:0]   quo;
    logic [SIZE_W-1:0] div;
  } div_st_t;

  logic [TEX_W-1:0] coord_u;
  logic [TEX_W-1:0] mag;
  div_st_t          st_nxt;
  div_st_t          st_r [0:DIV_STAGES];
  logic [UV_W:0]    mag_q;
  logic signed [UV_W-1:0] uv_nxt;
  logic signed [UV_W-1:0] uv_r;

  // Prepare magnitude, overflow test and first partial remainder
  assign coord_u = coord;
  assign mag = coord_u[TEX_W-1] ? (~coord_u + 16'd1) : coord_u;

  always_comb begin
    st_nxt.neg  = coord_u[TEX_W-1];
    st_nxt.zdiv = (size == '0);
    st_nxt.ovf  = ({1'b0, mag} >= {size, 4'b0000});
    st_nxt.nz   = (mag != '0);
    st_nxt.rem  = {2'b00, mag[TEX_W-1:4]};
    st_nxt.tail = {mag[3:0], 14'h0000};
    st_nxt.quo  = '0;
    st_nxt.div  = size;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= st_nxt;
  end

  // Restoring division, a fixed group of quotient bits per stage
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_st_t          nx;
    logic [REM_W-1:0] trial;

    always_comb begin
      nx    = st_r[g];
      trial = '0;
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        trial   = {nx.rem[REM_W-2:0], nx.tail[UV_W-1]};
        nx.tail = {nx.tail[UV_W-2:0], 1'b0};
        if (trial >= {1'b0, nx.div}) begin
          nx.rem = trial - {1'b0, nx.div};
          nx.quo = {nx.quo[UV_W-2:0], 1'b1};
        end else begin
          nx.rem = trial;
          nx.quo = {nx.quo[UV_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      st_r[g+1] <= nx;
    end
  end

  // Apply floor for negative values and saturate
  assign mag_q = {1'b0, st_r[DIV_STAGES].quo} +
                 {{UV_W{1'b0}}, (st_r[DIV_STAGES].rem != '0)};

  always_comb begin
    if (st_r[DIV_STAGES].zdiv) begin
      if (st_r[DIV_STAGES].neg) begin
        uv_nxt = UV_MIN;
      end else if (st_r[DIV_STAGES].nz) begin
        uv_nxt = UV_MAX;
      end else begin
        uv_nxt = '0;
      end
    end else if (st_r[DIV_STAGES].ovf) begin
      uv_nxt = st_r[DIV_STAGES].neg ? UV_MIN : UV_MAX;
    end else if (!st_r[DIV_STAGES].neg) begin
      uv_nxt = st_r[DIV_STAGES].quo[UV_W-1] ? UV_MAX : $signed(st_r[DIV_STAGES].quo);
    end else if (mag_q > UV_NEG_MAG) begin
      uv_nxt = UV_MIN;
    end else begin
      uv_nxt = $signed(UV_W'(~mag_q + 19'd1));
    end
  end

  always_ff @(posedge clk) begin
    uv_r <= uv_nxt;
  end

  assign uv = uv_r;

endmodule

@@ rtl/keyframe_vertex_interpolator_core.sv @@
// Top level of the keyframe vertex interpolator: config registers, three axis lanes, two divider lanes.
//
// Use: write the frame registers through cfg_we/cfg_index/cfg_wdata while no
// word is in flight; a write lands at the clock edge where cfg_we is high.
// A vertex corner word is taken at each edge with start high; busy stays low,
// so a new word may enter in every cycle.
// Depth: a word taken at a clock edge passes five register stages and then
// shows on the out_ ports, with out_valid high, for one cycle. Throughput:
// one word per cycle. The depth is set by the texture divider, which resolves
// six quotient bits in each of three stages between a prepare stage and a
// saturate stage; the position lanes (multiply, difference, blend multiply,
// add, scale) are matched to it.
// Reset (rst_n low at a clock edge) empties the pipeline and loads the
// register defaults: unit scale, zero translate, zero blend, 256 by 256 skin.
// Results cannot be held off: each appears for exactly one cycle and the
// receiver must take it then.
module keyframe_vertex_interpolator_core import kvi_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    start,
  output logic                    busy,
  input  logic [BYTE_W-1:0]       in_cur_x,
  input  logic [BYTE_W-1:0]       in_cur_y,
  input  logic [BYTE_W-1:0]       in_cur_z,
  input  logic [BYTE_W-1:0]       in_nxt_x,
  input  logic [BYTE_W-1:0]       in_nxt_y,
  input  logic [BYTE_W-1:0]       in_nxt_z,
  input  logic signed [TEX_W-1:0] in_tex_s,
  input  logic signed [TEX_W-1:0] in_tex_t,
  output logic                    out_valid,
  output logic signed [POS_W-1:0] out_pos_x,
  output logic signed [POS_W-1:0] out_pos_y,
  output logic signed [POS_W-1:0] out_pos_z,
  output logic signed [UV_W-1:0]  out_tex_u,
  output logic signed [UV_W-1:0]  out_tex_v
);

  cfg_t                  cfg;
  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] vld_nxt;
  logic [BYTE_W-1:0]     cur_b [3];
  logic [BYTE_W-1:0]     nxt_b [3];
  logic signed [POS_W-1:0] pos [3];

  kvi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Take a word whenever start is high
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Advance the valid bits alongside the data
  assign vld_nxt = {vld_r[PIPE_DEPTH-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[PIPE_DEPTH-1];

  // Position lanes, one per axis
  assign cur_b[0] = in_cur_x;
  assign cur_b[1] = in_cur_y;
  assign cur_b[2] = in_cur_z;
  assign nxt_b[0] = in_nxt_x;
  assign nxt_b[1] = in_nxt_y;
  assign nxt_b[2] = in_nxt_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    kvi_pos_lane u_pos (
      .clk        (clk),
      .cur_b      (cur_b[a]),
      .nxt_b      (nxt_b[a]),
      .cur_scale  (cfg.cur_scale[a*AXIS_W +: AXIS_W]),
      .cur_trans  (cfg.cur_trans[a*AXIS_W +: AXIS_W]),
      .next_scale (cfg.next_scale[a*AXIS_W +: AXIS_W]),
      .next_trans (cfg.next_trans[a*AXIS_W +: AXIS_W]),
      .blend      (cfg.blend),
      .pos        (pos[a])
    );
  end

  assign out_pos_x = pos[0];
  assign out_pos_y = pos[1];
  assign out_pos_z = pos[2];

  // Texture coordinate lanes
  kvi_tex_div u_div_s (
    .clk   (clk),
    .coord (in_tex_s),
    .size  (cfg.skin_w),
    .uv    (out_tex_u)
  );

  kvi_tex_div u_div_t (
    .clk   (clk),
    .coord (in_tex_t),
    .size  (cfg.skin_h),
    .uv    (out_tex_v)
  );

endmodule
